FILE: hw/rtl/dltq_pkg.sv
// Package with the word types, codes and helpers of the delta-list timer queue.
package dltq_pkg;

    localparam int SLOT_BITS   = 4;
    localparam int NUM_SLOTS   = 16;
    localparam int DELAY_BITS  = 48;
    localparam int STATUS_BITS = 3;
    localparam int COUNT_BITS  = 5;

    // Command codes of an input word.
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_CANCEL  = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    // Status codes of a result word.
    localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOT_PENDING = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_PENDING     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_ZERO_DELAY  = 3'd4;

    typedef struct packed {
        logic [1:0]            command;
        logic [SLOT_BITS-1:0]  slot_id;
        logic [DELAY_BITS-1:0] delay;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   expired;
        logic [SLOT_BITS-1:0]   expired_slot;
        logic                   last;
        logic [COUNT_BITS-1:0]  pending_count;
    } t_out_word;

    // One list entry, stored at the address of its slot id.
    typedef struct packed {
        logic [SLOT_BITS-1:0]  next_slot;
        logic [DELAY_BITS-1:0] delta;
    } t_entry;

    // Result word that reports a status and no expiry.
    function automatic t_out_word status_word(input logic [STATUS_BITS-1:0] status,
                                              input logic [COUNT_BITS-1:0]  count);
        t_out_word w;
        w.status        = status;
        w.expired       = 1'b0;
        w.expired_slot  = '0;
        w.last          = 1'b1;
        w.pending_count = count;
        return w;
    endfunction

endpackage

FILE: hw/rtl/delta_list_timer_queue_core.sv
// Top level of the delta-list timer queue: list memory, walk sequencer and result register.
//
//  Channel  Ports                                   Direction  Word
//  in       i_in_valid, o_in_stall, i_in_word       to core    command, slot_id, delay
//  out      o_out_valid, i_out_stall, o_out_word    from core  status, expiry, count
//
// The pending list is linked through one memory addressed by slot id, with registered read
// data. Enqueue and cancel walk it one entry at a time (read, then compare).
// Reset clears the count, the pending flags and the control state; the memory is not
// cleared, since only linked entries are ever read. A stalled result holds the core only
// when the next result is due; otherwise a new word is taken while it waits.
module delta_list_timer_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dltq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dltq_pkg::t_out_word o_out_word
);
    import dltq_pkg::*;

    // Fill level at which an enqueue is refused.
    localparam logic [COUNT_BITS:0] L_FULL =
        (COUNT_BITS+1)'((QUEUE_DEPTH < 32) ? QUEUE_DEPTH : 32);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_ENQ_RD,
        S_ENQ_CHK,
        S_ENQ_INS,
        S_ENQ_SUCC,
        S_ENQ_LINK,
        S_CAN_RD,
        S_CAN_CHK,
        S_CAN_SUCC,
        S_CAN_LINK,
        S_TICK_CHK,
        S_TICK_EXP
    } t_state;

    t_state                  r_state, n_state;
    t_state                  r_after, n_after;
    logic [SLOT_BITS-1:0]    r_slot, n_slot;
    logic [DELAY_BITS-1:0]   r_rem, n_rem;
    logic [SLOT_BITS-1:0]    r_cur, n_cur;
    logic [SLOT_BITS-1:0]    r_prev, n_prev;
    logic [DELAY_BITS-1:0]   r_prev_delta, n_prev_delta;
    logic                    r_prev_valid, n_prev_valid;
    logic [COUNT_BITS-1:0]   r_k, n_k;
    logic                    r_has_succ, n_has_succ;
    logic                    r_first, n_first;
    t_entry                  r_vic, n_vic;
    logic [SLOT_BITS-1:0]    r_head, n_head;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic [NUM_SLOTS-1:0]    r_pending, n_pending;
    t_out_word               r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    t_out_word               r_out, n_out;

    // List memory and its ports.
    t_entry                  r_mem [NUM_SLOTS];
    t_entry                  r_rd;
    logic                    w_rd_en;
    logic [SLOT_BITS-1:0]    w_rd_addr;
    logic                    w_wr_en;
    logic [SLOT_BITS-1:0]    w_wr_addr;
    t_entry                  w_wr_data;

    logic                    w_accept;
    logic                    w_out_free;
    logic [DELAY_BITS-1:0]   w_tick_delta;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Head delta after the tick decrement; only the first entry of a tick counts down.
    always_comb begin
        w_tick_delta = r_rd.delta;
        if (r_first && (r_rd.delta != '0)) begin
            w_tick_delta = r_rd.delta - DELAY_BITS'(1);
        end
    end

    // Next-state logic of the sequencer and the memory port controls.
    always_comb begin
        n_state      = r_state;
        n_after      = r_after;
        n_slot       = r_slot;
        n_rem        = r_rem;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_prev_delta = r_prev_delta;
        n_prev_valid = r_prev_valid;
        n_k          = r_k;
        n_has_succ   = r_has_succ;
        n_first      = r_first;
        n_vic        = r_vic;
        n_head       = r_head;
        n_count      = r_count;
        n_pending    = r_pending;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_cur;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_slot;
        w_wr_data    = '{next_slot: r_cur, delta: r_rem};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_slot       = i_in_word.slot_id;
                    n_rem        = i_in_word.delay;
                    n_cur        = r_head;
                    n_k          = '0;
                    n_prev_valid = 1'b0;
                    n_has_succ   = 1'b0;
                    n_after      = S_IDLE;
                    n_res        = status_word(ST_OK, r_count);
                    n_state      = S_EMIT;
                    case (i_in_word.command)
                        CMD_ENQUEUE: begin
                            if (i_in_word.delay == '0) begin
                                n_res = status_word(ST_ZERO_DELAY, r_count);
                            end else if (r_pending[i_in_word.slot_id]) begin
                                n_res = status_word(ST_PENDING, r_count);
                            end else if ({1'b0, r_count} >= L_FULL) begin
                                n_res = status_word(ST_FULL, r_count);
                            end else begin
                                n_state = S_ENQ_RD;
                            end
                        end
                        CMD_CANCEL: begin
                            if (!r_pending[i_in_word.slot_id]) begin
                                n_res = status_word(ST_NOT_PENDING, r_count);
                            end else begin
                                n_state = S_CAN_RD;
                            end
                        end
                        CMD_TICK: begin
                            if (r_count != '0) begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_head;
                                n_first   = 1'b1;
                                n_state   = S_TICK_CHK;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            // Hand the held result to the output register once it is free.
            S_EMIT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = r_after;
                end
            end

            // Enqueue walk: read the next entry, or insert at the tail.
            S_ENQ_RD: begin
                if (r_k == r_count) begin
                    n_state = S_ENQ_INS;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_cur;
                    n_state   = S_ENQ_CHK;
                end
            end

            // Step past entries not later than the remaining delay; ties keep arrival order.
            S_ENQ_CHK: begin
                if (r_rd.delta <= r_rem) begin
                    n_rem        = r_rem - r_rd.delta;
                    n_prev       = r_cur;
                    n_prev_delta = r_rd.delta;
                    n_prev_valid = 1'b1;
                    n_cur        = r_rd.next_slot;
                    n_k          = r_k + COUNT_BITS'(1);
                    n_state      = S_ENQ_RD;
                end else begin
                    n_has_succ = 1'b1;
                    n_state    = S_ENQ_INS;
                end
            end

            // Write the new entry in front of the current one.
            S_ENQ_INS: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_slot;
                w_wr_data = '{next_slot: r_cur, delta: r_rem};
                n_state   = r_has_succ ? S_ENQ_SUCC : S_ENQ_LINK;
            end

            // The successor now counts from the new entry.
            S_ENQ_SUCC: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cur;
                w_wr_data = '{next_slot: r_rd.next_slot, delta: r_rd.delta - r_rem};
                n_state   = S_ENQ_LINK;
            end

            // Point the predecessor, or the head, at the new entry.
            S_ENQ_LINK: begin
                if (r_prev_valid) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_prev;
                    w_wr_data = '{next_slot: r_slot, delta: r_prev_delta};
                end else begin
                    n_head = r_slot;
                end
                n_count           = r_count + COUNT_BITS'(1);
                n_pending[r_slot] = 1'b1;
                n_res             = status_word(ST_OK, r_count + COUNT_BITS'(1));
                n_after           = S_IDLE;
                n_state           = S_EMIT;
            end

            // Cancel walk: read the current entry.
            S_CAN_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_cur;
                n_state   = S_CAN_CHK;
            end

            // If this is the slot, keep its entry and fetch the successor if there is one; else step on.
            S_CAN_CHK: begin
                if (r_cur == r_slot) begin
                    n_vic = r_rd;
                    if ((r_k + COUNT_BITS'(1)) < r_count) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_rd.next_slot;
                        n_state   = S_CAN_SUCC;
                    end else begin
                        n_state = S_CAN_LINK;
                    end
                end else begin
                    n_prev       = r_cur;
                    n_prev_delta = r_rd.delta;
                    n_prev_valid = 1'b1;
                    n_cur        = r_rd.next_slot;
                    n_k          = r_k + COUNT_BITS'(1);
                    n_state      = S_CAN_RD;
                end
            end

            // Credit the cancelled delta to the successor.
            S_CAN_SUCC: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_vic.next_slot;
                w_wr_data = '{next_slot: r_rd.next_slot, delta: r_rd.delta + r_vic.delta};
                n_state   = S_CAN_LINK;
            end

            // Unlink the cancelled entry.
            S_CAN_LINK: begin
                if (r_prev_valid) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_prev;
                    w_wr_data = '{next_slot: r_vic.next_slot, delta: r_prev_delta};
                end else begin
                    n_head = r_vic.next_slot;
                end
                n_count           = r_count - COUNT_BITS'(1);
                n_pending[r_slot] = 1'b0;
                n_res             = status_word(ST_OK, r_count - COUNT_BITS'(1));
                n_after           = S_IDLE;
                n_state           = S_EMIT;
            end

            // Tick: decide whether the entry just read at the head expires.
            S_TICK_CHK: begin
                if (w_tick_delta != '0) begin
                    if (r_first) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_head;
                        w_wr_data = '{next_slot: r_rd.next_slot, delta: w_tick_delta};
                        n_res     = status_word(ST_OK, r_count);
                    end else begin
                        n_res.last = 1'b1;
                    end
                    n_after = S_IDLE;
                    n_state = S_EMIT;
                end else if (r_first) begin
                    n_state = S_TICK_EXP;
                end else begin
                    n_res.last = 1'b0;
                    n_after    = S_TICK_EXP;
                    n_state    = S_EMIT;
                end
            end

            // Remove the head and look at the next entry.
            S_TICK_EXP: begin
                n_res.status        = ST_OK;
                n_res.expired       = 1'b1;
                n_res.expired_slot  = r_head;
                n_res.last          = 1'b0;
                n_res.pending_count = r_count - COUNT_BITS'(1);
                n_count             = r_count - COUNT_BITS'(1);
                n_pending[r_head]   = 1'b0;
                n_head              = r_rd.next_slot;
                if (r_count > COUNT_BITS'(1)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_rd.next_slot;
                    n_first   = 1'b0;
                    n_state   = S_TICK_CHK;
                end else begin
                    n_res.last = 1'b1;
                    n_after    = S_IDLE;
                    n_state    = S_EMIT;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_count     <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
        r_slot       <= n_slot;
        r_rem        <= n_rem;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_prev_delta <= n_prev_delta;
        r_prev_valid <= n_prev_valid;
        r_k          <= n_k;
        r_has_succ   <= n_has_succ;
        r_first      <= n_first;
        r_vic        <= n_vic;
        r_head       <= n_head;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    // List memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: hw/rtl/dltq_checker.sv
// Port checker of the delta-list timer queue and its bind to the top level.
module dltq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input dltq_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input dltq_pkg::t_out_word o_out_word
);
    import dltq_pkg::*;

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // A result that reports no expiry closes its item and names no slot.
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.expired |->
            o_out_word.last && (o_out_word.expired_slot == '0))
        else $error("non-expiry result not marked last or carries a slot");

    // Expiries always carry an ok status.
    a_expiry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.expired |-> o_out_word.status == ST_OK)
        else $error("expiry result with an error status");

    // Pending count never exceeds the number of slots.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.pending_count <= COUNT_BITS'(NUM_SLOTS))
        else $error("pending count out of range");

    // A rejected enqueue is never reported full while the queue is empty.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_FULL) |-> o_out_word.pending_count != '0)
        else $error("queue reported full while empty");

endmodule

bind delta_list_timer_queue_core dltq_checker u_dltq_checker (.*);

FILE: dv/tb_delta_list_timer_queue_core.sv
// Self-checking testbench of the delta-list timer queue core, with its scoreboard and stimulus.
module tb_delta_list_timer_queue_core;

    import dltq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int ITEM_COUNT     = 430;
    localparam int CALM_FROM      = 370;
    localparam int HOLD_OFF_AT    = 150;
    localparam int HOLD_OFF_LEN   = 250;
    localparam int DRAIN_CYCLES   = 80;
    localparam int QUIET_LIMIT    = 3000;

    // Command code outside the defined set; the core must answer it like a no-op.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

    // Scoreboard: keeps its own copy of the delta list and queues the words it predicts.
    class timer_scoreboard;
        logic [SLOT_BITS-1:0]  slot_order [DEPTH];
        logic [DELAY_BITS-1:0] delta_order [DEPTH];
        int                    queued;
        logic [NUM_SLOTS-1:0]  pending_mask;
        t_out_word             expected_results [$];
        int unsigned           mismatches;
        int unsigned           words_checked;
        int unsigned           expiries_seen;
        int unsigned           longest_burst;
        int unsigned           enqueues_ok;
        int unsigned           cancels_ok;
        int unsigned           ticks_taken;

        function new();
            queued        = 0;
            pending_mask  = '0;
            mismatches    = 0;
            words_checked = 0;
            expiries_seen = 0;
            longest_burst = 0;
            enqueues_ok   = 0;
            cancels_ok    = 0;
            ticks_taken   = 0;
        endfunction

        function void push_result(logic [STATUS_BITS-1:0] status, logic expired,
                                  logic [SLOT_BITS-1:0] slot, logic last);
            t_out_word w;
            w.status        = status;
            w.expired       = expired;
            w.expired_slot  = slot;
            w.last          = last;
            w.pending_count = COUNT_BITS'(queued);
            expected_results.push_back(w);
        endfunction

        // Close the gap left by the entry at pos.
        function void drop_entry(int pos);
            for (int i = pos; i + 1 < queued; i++) begin
                slot_order[i]  = slot_order[i + 1];
                delta_order[i] = delta_order[i + 1];
            end
            queued--;
        endfunction

        // Walk the list, consuming every delta not above the remaining delay, and insert there.
        function logic [STATUS_BITS-1:0] enqueue_slot(logic [SLOT_BITS-1:0] slot,
                                                      logic [DELAY_BITS-1:0] delay);
            int                    pos;
            logic [DELAY_BITS-1:0] remaining;
            pos       = 0;
            remaining = delay;
            if (remaining == '0) return ST_ZERO_DELAY;
            if (pending_mask[slot]) return ST_PENDING;
            if (queued >= DEPTH) return ST_FULL;
            while (pos < queued && delta_order[pos] <= remaining) begin
                remaining = remaining - delta_order[pos];
                pos++;
            end
            for (int i = queued; i > pos; i--) begin
                slot_order[i]  = slot_order[i - 1];
                delta_order[i] = delta_order[i - 1];
            end
            slot_order[pos]  = slot;
            delta_order[pos] = remaining;
            queued++;
            if (pos + 1 < queued) delta_order[pos + 1] = delta_order[pos + 1] - remaining;
            pending_mask[slot] = 1'b1;
            return ST_OK;
        endfunction

        // Unlink a slot and hand its delta on to the entry behind it.
        function logic [STATUS_BITS-1:0] cancel_slot(logic [SLOT_BITS-1:0] slot);
            int pos;
            if (!pending_mask[slot]) return ST_NOT_PENDING;
            pos = 0;
            while (pos < queued && slot_order[pos] != slot) pos++;
            if (pos < queued) begin
                if (pos + 1 < queued) delta_order[pos + 1] = delta_order[pos + 1] + delta_order[pos];
                drop_entry(pos);
            end
            pending_mask[slot] = 1'b0;
            return ST_OK;
        endfunction

        // Count the head down and expire it together with every zero delta behind it.
        function void tick_list();
            int                   burst;
            logic [SLOT_BITS-1:0] id;
            t_out_word            tail;
            burst = 0;
            if (queued > 0) begin
                if (delta_order[0] != '0) delta_order[0] = delta_order[0] - 1'b1;
                while (queued > 0 && delta_order[0] == '0 && burst < NUM_SLOTS) begin
                    id = slot_order[0];
                    drop_entry(0);
                    pending_mask[id] = 1'b0;
                    push_result(ST_OK, 1'b1, id, 1'b0);
                    burst++;
                end
            end
            if (burst > 0) begin
                tail      = expected_results.pop_back();
                tail.last = 1'b1;
                expected_results.push_back(tail);
                expiries_seen += burst;
                if (burst > longest_burst) longest_burst = burst;
            end else begin
                push_result(ST_OK, 1'b0, '0, 1'b1);
            end
        endfunction

        // An input word has been taken by the core.
        function void note_accepted(t_in_word w);
            logic [STATUS_BITS-1:0] status;
            case (w.command)
                CMD_ENQUEUE: begin
                    status = enqueue_slot(w.slot_id, w.delay);
                    if (status == ST_OK) enqueues_ok++;
                    push_result(status, 1'b0, '0, 1'b1);
                end
                CMD_CANCEL: begin
                    status = cancel_slot(w.slot_id);
                    if (status == ST_OK) cancels_ok++;
                    push_result(status, 1'b0, '0, 1'b1);
                end
                CMD_TICK: begin
                    ticks_taken++;
                    tick_list();
                end
                default: begin
                    push_result(ST_OK, 1'b0, '0, 1'b1);
                end
            endcase
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        // A result word has left the core; compare it with the oldest prediction.
        task check_result(t_out_word got);
            t_out_word want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end else begin
                want = expected_results.pop_front();
                words_checked++;
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.expired != want.expired)
                    report_mismatch("expired", got.expired, want.expired);
                if (got.expired_slot != want.expired_slot)
                    report_mismatch("expired_slot", got.expired_slot, want.expired_slot);
                if (got.last != want.last)
                    report_mismatch("last", got.last, want.last);
                if (got.pending_count != want.pending_count)
                    report_mismatch("pending_count", got.pending_count, want.pending_count);
            end
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    timer_scoreboard sb = new();
    int              words_sent;
    bit              calm;
    int              quiet_cycles = 0;

    delta_list_timer_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Both handshakes are sampled at the clock edge, before the edge's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_accepted(i_in_word);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
    end

    // Watchdog: ends the run when no word has moved on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("[%0t] watchdog expired with %0d results outstanding", $time,
                     sb.expected_results.size());
            $display("delta_list_timer_queue_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function t_in_word make_word(logic [1:0] command, logic [SLOT_BITS-1:0] slot,
                                 logic [DELAY_BITS-1:0] delay);
        t_in_word w;
        w.command = command;
        w.slot_id = slot;
        w.delay   = delay;
        return w;
    endfunction

    function logic [DELAY_BITS-1:0] wide_delay();
        return {16'($urandom_range(0, 65535)), 32'($urandom)};
    endfunction

    // Offer one word, possibly after a short gap, and hold it until the core takes it.
    task automatic send_word(input t_in_word w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
        if (words_sent >= CALM_FROM) calm = 1'b1;
    endtask

    // Clear every slot, then arm all sixteen so that three ticks expire them in bulk.
    task automatic fill_and_expire();
        bit same_delay;
        same_delay = ($urandom_range(0, 1) == 1);
        for (int s = 0; s < NUM_SLOTS; s++)
            send_word(make_word(CMD_CANCEL, SLOT_BITS'(s), wide_delay()));
        for (int s = 0; s < NUM_SLOTS; s++)
            send_word(make_word(CMD_ENQUEUE, SLOT_BITS'(s),
                                same_delay ? DELAY_BITS'(1) : DELAY_BITS'($urandom_range(1, 3))));
        repeat (3) send_word(make_word(CMD_TICK, SLOT_BITS'($urandom_range(0, 15)), wide_delay()));
    endtask

    // One random word, weighted towards short timers so that ticks keep expiring them.
    task automatic send_random_word();
        int                    pick;
        int                    shape;
        logic [DELAY_BITS-1:0] delay;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 9);
        if (shape < 7) delay = DELAY_BITS'($urandom_range(1, 12));
        else if (shape < 8) delay = '0;
        else delay = wide_delay();
        if (pick < 40)
            send_word(make_word(CMD_ENQUEUE, SLOT_BITS'($urandom_range(0, 15)), delay));
        else if (pick < 55)
            send_word(make_word(CMD_CANCEL, SLOT_BITS'($urandom_range(0, 15)), wide_delay()));
        else if (pick < 97)
            send_word(make_word(CMD_TICK, SLOT_BITS'($urandom_range(0, 15)), wide_delay()));
        else
            send_word(make_word(CMD_UNKNOWN, SLOT_BITS'($urandom_range(0, 15)), wide_delay()));
    endtask

    // Result side: short random stalls, one long hold-off to back the core up, then none.
    initial begin
        bit held;
        held        = 1'b0;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held && words_sent >= HOLD_OFF_AT) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Main sequence: reset, directed words, random words, drain and verdict.
    initial begin
        int next_fill;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        words_sent   = 0;
        calm         = 1'b0;
        next_fill    = 60;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Status cases on an empty list and on a single long timer.
        send_word(make_word(CMD_TICK, 4'd15, DELAY_MAX));
        send_word(make_word(CMD_CANCEL, 4'd0, '0));
        send_word(make_word(CMD_ENQUEUE, 4'd0, '0));
        send_word(make_word(CMD_ENQUEUE, 4'd15, DELAY_MAX));
        send_word(make_word(CMD_ENQUEUE, 4'd15, DELAY_BITS'(5)));
        send_word(make_word(CMD_ENQUEUE, 4'd15, '0));
        send_word(make_word(CMD_UNKNOWN, 4'd15, DELAY_MAX));
        send_word(make_word(CMD_CANCEL, 4'd15, DELAY_MAX));

        // Ties, insertion ahead of the head, a middle cancel and a multiple expiry.
        send_word(make_word(CMD_ENQUEUE, 4'd1, DELAY_BITS'(2)));
        send_word(make_word(CMD_ENQUEUE, 4'd2, DELAY_BITS'(2)));
        send_word(make_word(CMD_ENQUEUE, 4'd3, DELAY_BITS'(1)));
        send_word(make_word(CMD_ENQUEUE, 4'd4, DELAY_BITS'(3)));
        send_word(make_word(CMD_ENQUEUE, 4'd5, DELAY_BITS'(5)));
        send_word(make_word(CMD_CANCEL, 4'd4, '0));
        send_word(make_word(CMD_TICK, 4'd0, '0));
        send_word(make_word(CMD_TICK, 4'd0, '0));
        send_word(make_word(CMD_CANCEL, 4'd5, '0));
        send_word(make_word(CMD_ENQUEUE, 4'd0, DELAY_BITS'(1)));
        send_word(make_word(CMD_TICK, 4'd0, '0));

        while (words_sent < ITEM_COUNT) begin
            if (words_sent >= next_fill && !calm) begin
                fill_and_expire();
                next_fill += 110;
            end else begin
                send_random_word();
            end
        end
        i_in_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d words: %0d timers armed, %0d cancelled, %0d ticks, %0d result words checked.",
                 words_sent, sb.enqueues_ok, sb.cancels_ok, sb.ticks_taken, sb.words_checked);
        $display("Saw %0d expiries, up to %0d from one tick, with a long output hold-off mid-run.",
                 sb.expiries_seen, sb.longest_burst);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("delta_list_timer_queue_core verification clean");
        end else begin
            $display("delta_list_timer_queue_core verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dltq_pkg.sv
hw/rtl/delta_list_timer_queue_core.sv
hw/rtl/dltq_checker.sv
dv/tb_delta_list_timer_queue_core.sv
